>>> rtl/qkv_split_bias_transpose_assert.svh
// Assertion macros shared by the checker.
`ifndef QKV_SPLIT_BIAS_TRANSPOSE_ASSERT_SVH
`define QKV_SPLIT_BIAS_TRANSPOSE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define QKVSBT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define QKVSBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qkvsbt_pkg.sv
package qkvsbt_pkg;

  localparam int DW       = 24;  // dest_index width
  localparam int PADDR_W  = 4;   // four 32-bit registers
  localparam int PDATA_W  = 32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REG_BATCH_COUNT = 2'd0,
    REG_TOKEN_COUNT = 2'd1,
    REG_HEAD_COUNT  = 2'd2,
    REG_HEAD_WIDTH  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic               opcode;
    logic [12:0]        bias_slot;
    logic signed [31:0] sample;
  } item_word_t;

  typedef struct packed {
    logic [1:0]         target;
    logic [DW-1:0]      dest_index;
    logic signed [31:0] result_value;
    logic               final_res;
  } res_word_t;

  // position info of one data element, without the value
  typedef struct packed {
    logic [1:0]    target;
    logic [DW-1:0] dest_index;
    logic          final_res;
  } elem_tag_t;

  // raw register contents
  typedef struct packed {
    logic [4:0] batch_count;
    logic [9:0] token_count;
    logic [4:0] head_count;
    logic [7:0] head_width;
  } cfg_view_t;

  // zero counts as one, anything above top counts as top
  function automatic int unsigned clamp_size(int unsigned v, int unsigned top);
    int unsigned r;
    r = v;
    if (v == 0) r = 1;
    else if (v > top) r = top;
    return r;
  endfunction

endpackage

>>> rtl/qkv_split_bias_transpose.sv
// QKV split, bias add and head-major transpose.
// Item channel (item_valid/item_ready/item): one word per element of the fused
// projection in source order batch, token, part, head, lane. opcode OP_LOAD
// writes sample into the bias table at bias_slot (slots past the table are
// dropped) and yields nothing; OP_DATA is a data element.
// Result channel (res_valid/res_ready/res): one word per data element with its
// part (0 query, 1 key, 2 value), head-major index, Q16.16 saturated sum and a
// flag on the last element of the tensor.
// APB port: batch_count, token_count, head_count, head_width at 0x0..0xC.
// Any write restarts the position at the first element.
// Pipeline: the bias table is read at the edge that takes the item; the add
// lands in the output register when the read stage moves on, which a stall can delay.
// Throughput: one word per cycle while item_ready is high, loads and data alike; the bias table has
// one write and one read port and each word uses one of them once.
// A load followed at once by a data element for the same slot needs no bypass:
// the write lands at the edge before the read is issued.
// Stall: a full output register plus a held read stage drop item_ready.
// Reset: registers go to 1, position to zero, pipeline empty; the bias table
// is not cleared and needs loading before use.
module qkv_split_bias_transpose import qkvsbt_pkg::*; #(
  parameter int MAX_BATCH      = 16,
  parameter int MAX_TOKENS     = 512,
  parameter int MAX_HEADS      = 16,
  parameter int MAX_HEAD_WIDTH = 128,
  parameter int PARTS          = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_word_t         item,
  output logic               res_valid,
  input  logic               res_ready,
  output res_word_t          res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int DEPTH = PARTS * MAX_HEADS * MAX_HEAD_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SWW   = $clog2(MAX_TOKENS * MAX_HEAD_WIDTH + 1);

  cfg_view_t          cfg;
  logic [SWW-1:0]     sw;
  logic               accept, data_acc, load_wr, slot_ok, s1_move;
  logic [AW-1:0]      rd_slot;
  logic [31:0]        bias;
  elem_tag_t          tag;

  // read stage: element waiting for its bias word
  logic               s1_valid;
  logic signed [31:0] s1_sample;
  elem_tag_t          s1_tag;

  logic signed [32:0] sum;
  logic signed [31:0] sat;

  assign pready = 1'b1;

  qkvsbt_cfg #(
    .MAX_TOKENS     (MAX_TOKENS),
    .MAX_HEAD_WIDTH (MAX_HEAD_WIDTH),
    .SWW            (SWW)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .sw      (sw)
  );

  // output side frees up -> read stage can move -> new word can enter
  assign s1_move    = s1_valid && (!res_valid || res_ready);
  assign item_ready = !rst && (!s1_valid || !res_valid || res_ready);
  assign accept     = item_valid && item_ready;
  assign data_acc   = accept && (item.opcode == OP_DATA);
  assign slot_ok    = 32'(item.bias_slot) < 32'(DEPTH);
  assign load_wr    = accept && (item.opcode == OP_LOAD) && slot_ok;

  // position counters see the write strobe at the write edge itself
  qkvsbt_pos #(
    .MAX_BATCH      (MAX_BATCH),
    .MAX_TOKENS     (MAX_TOKENS),
    .MAX_HEADS      (MAX_HEADS),
    .MAX_HEAD_WIDTH (MAX_HEAD_WIDTH),
    .PARTS          (PARTS),
    .AW             (AW),
    .SWW            (SWW)
  ) u_pos (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .clear   (psel && penable && pwrite),
    .sw      (sw),
    .step    (data_acc),
    .rd_slot (rd_slot),
    .tag     (tag)
  );

  qkvsbt_bias_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (AW'(item.bias_slot)),
    .wr_data (item.sample),
    .rd_en   (data_acc),
    .rd_addr (rd_slot),
    .rd_data (bias)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_acc) begin
      s1_sample <= item.sample;
      s1_tag    <= tag;
    end
  end

  // exact 33-bit sum; overflow shows as the two top bits differing
  always_comb begin
    sum = 33'(s1_sample) + 33'($signed(bias));
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? SAT_MIN : SAT_MAX;
    end else begin
      sat = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_move) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res.target       <= s1_tag.target;
      res.dest_index   <= s1_tag.dest_index;
      res.result_value <= sat;
      res.final_res    <= s1_tag.final_res;
    end
  end

endmodule

>>> rtl/qkvsbt_bias_ram.sv
module qkvsbt_bias_ram import qkvsbt_pkg::*; #(
  parameter int DEPTH = 6144,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // data held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/qkvsbt_cfg.sv
module qkvsbt_cfg import qkvsbt_pkg::*; #(
  parameter int MAX_TOKENS     = 512,
  parameter int MAX_HEAD_WIDTH = 128,
  parameter int SWW            = 17
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output cfg_view_t          cfg,
  output logic [SWW-1:0]     sw
);

  localparam int TSW = $clog2(MAX_TOKENS + 1);
  localparam int WSW = $clog2(MAX_HEAD_WIDTH + 1);

  reg_idx_t       idx;
  logic           wr_en;
  logic [9:0]     tok_new;
  logic [7:0]     wid_new;
  logic [TSW-1:0] s_new;
  logic [WSW-1:0] w_new;

  assign idx   = reg_idx_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  // tokens * width, taken from the value being written so it is ready at once
  assign tok_new = (idx == REG_TOKEN_COUNT) ? pwdata[9:0] : cfg.token_count;
  assign wid_new = (idx == REG_HEAD_WIDTH) ? pwdata[7:0] : cfg.head_width;
  assign s_new   = TSW'(clamp_size(32'(tok_new), MAX_TOKENS));
  assign w_new   = WSW'(clamp_size(32'(wid_new), MAX_HEAD_WIDTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.batch_count <= 5'd1;
      cfg.token_count <= 10'd1;
      cfg.head_count  <= 5'd1;
      cfg.head_width  <= 8'd1;
      sw              <= SWW'(1);
    end else begin
      if (wr_en) begin
        unique case (idx)
          REG_BATCH_COUNT: cfg.batch_count <= pwdata[4:0];
          REG_TOKEN_COUNT: cfg.token_count <= pwdata[9:0];
          REG_HEAD_COUNT:  cfg.head_count  <= pwdata[4:0];
          REG_HEAD_WIDTH:  cfg.head_width  <= pwdata[7:0];
          default:         cfg.head_width  <= cfg.head_width;
        endcase
        sw <= SWW'(SWW'(s_new) * SWW'(w_new));
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_BATCH_COUNT: prdata = PDATA_W'(cfg.batch_count);
      REG_TOKEN_COUNT: prdata = PDATA_W'(cfg.token_count);
      REG_HEAD_COUNT:  prdata = PDATA_W'(cfg.head_count);
      REG_HEAD_WIDTH:  prdata = PDATA_W'(cfg.head_width);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/qkvsbt_pos.sv
module qkvsbt_pos import qkvsbt_pkg::*; #(
  parameter int MAX_BATCH      = 16,
  parameter int MAX_TOKENS     = 512,
  parameter int MAX_HEADS      = 16,
  parameter int MAX_HEAD_WIDTH = 128,
  parameter int PARTS          = 3,
  parameter int AW             = 13,
  parameter int SWW            = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  cfg_view_t      cfg,
  input  logic           clear,
  input  logic [SWW-1:0] sw,
  input  logic           step,
  output logic [AW-1:0]  rd_slot,
  output elem_tag_t      tag
);

  localparam int LW  = (MAX_HEAD_WIDTH > 1) ? $clog2(MAX_HEAD_WIDTH) : 1;
  localparam int HNW = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
  localparam int PW  = (PARTS > 1) ? $clog2(PARTS) : 1;
  localparam int TW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int BW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

  logic [LW-1:0]  lane, lane_next, lane_last;
  logic [HNW-1:0] head, head_next, head_last;
  logic [PW-1:0]  part, part_next;
  logic [TW-1:0]  token, token_next, token_last;
  logic [BW-1:0]  batch, batch_next, batch_last;
  logic [AW-1:0]  slot, slot_next;
  logic [DW-1:0]  rowbase, rowbase_next;  // dest of lane 0 in the current row
  logic [DW-1:0]  tokbase, tokbase_next;  // dest of head 0, lane 0 of this token
  logic [DW-1:0]  wstep, sw24, tok_w, row_w;
  logic           lane_end, head_end, part_end, tok_end, bat_end;

  assign lane_last  = LW'(clamp_size(32'(cfg.head_width), MAX_HEAD_WIDTH) - 1);
  assign head_last  = HNW'(clamp_size(32'(cfg.head_count), MAX_HEADS) - 1);
  assign token_last = TW'(clamp_size(32'(cfg.token_count), MAX_TOKENS) - 1);
  assign batch_last = BW'(clamp_size(32'(cfg.batch_count), MAX_BATCH) - 1);
  assign wstep      = DW'(clamp_size(32'(cfg.head_width), MAX_HEAD_WIDTH));
  assign sw24       = DW'(sw);

  assign lane_end = (lane == lane_last);
  assign head_end = (head == head_last);
  assign part_end = (part == PW'(PARTS - 1));
  assign tok_end  = (token == token_last);
  assign bat_end  = (batch == batch_last);

  assign tok_w = tokbase + wstep;
  // at the end of a batch this is the next batch's base
  assign row_w = rowbase + wstep;

  always_comb begin
    lane_next    = lane;
    head_next    = head;
    part_next    = part;
    token_next   = token;
    batch_next   = batch;
    slot_next    = slot;
    rowbase_next = rowbase;
    tokbase_next = tokbase;
    if (clear) begin
      lane_next    = '0;
      head_next    = '0;
      part_next    = '0;
      token_next   = '0;
      batch_next   = '0;
      slot_next    = '0;
      rowbase_next = '0;
      tokbase_next = '0;
    end else if (step) begin
      slot_next = slot + AW'(1);
      if (!lane_end) begin
        lane_next = lane + LW'(1);
      end else begin
        lane_next = '0;
        if (!head_end) begin
          head_next    = head + HNW'(1);
          rowbase_next = rowbase + sw24;
        end else begin
          head_next = '0;
          if (!part_end) begin
            part_next    = part + PW'(1);
            rowbase_next = tokbase;
          end else begin
            part_next = '0;
            slot_next = '0;
            if (!tok_end) begin
              token_next   = token + TW'(1);
              tokbase_next = tok_w;
              rowbase_next = tok_w;
            end else begin
              token_next = '0;
              if (!bat_end) begin
                batch_next   = batch + BW'(1);
                tokbase_next = row_w;
                rowbase_next = row_w;
              end else begin
                batch_next   = '0;
                tokbase_next = '0;
                rowbase_next = '0;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane    <= '0;
      head    <= '0;
      part    <= '0;
      token   <= '0;
      batch   <= '0;
      slot    <= '0;
      rowbase <= '0;
      tokbase <= '0;
    end else begin
      lane    <= lane_next;
      head    <= head_next;
      part    <= part_next;
      token   <= token_next;
      batch   <= batch_next;
      slot    <= slot_next;
      rowbase <= rowbase_next;
      tokbase <= tokbase_next;
    end
  end

  assign rd_slot        = slot;
  assign tag.target     = 2'(part);
  assign tag.dest_index = rowbase + DW'(lane);
  assign tag.final_res  = lane_end && head_end && part_end && tok_end && bat_end;

endmodule

>>> rtl/qkvsbt_checker.sv
`include "qkv_split_bias_transpose_assert.svh"

module qkvsbt_checker import qkvsbt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input item_word_t item,
  input logic       res_valid,
  input logic       res_ready,
  input res_word_t  res,
  input logic       pready
);

  // a result word follows its data element through the read stage and the output register
  `QKVSBT_ASSERT_NOW(a_res_latency, $rose(res_valid), $past(item_valid && item_ready && (item.opcode == OP_DATA), 2), "result without matching data word")

  // a stalled result word holds
  `QKVSBT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "stalled result changed")

  `QKVSBT_ASSERT_NOW(a_target_code, res_valid, res.target != 2'd3, "bad target code")

  `QKVSBT_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind qkv_split_bias_transpose qkvsbt_checker u_checker (.*);
